FILE: sv/grid_min_path_length_dp_unit_assert.svh
// assertion macros for the grid shortest path unit
// no dependencies; included by the modules that carry assertions
`ifndef GRID_MIN_PATH_LENGTH_DP_UNIT_ASSERT_SVH
`define GRID_MIN_PATH_LENGTH_DP_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GMPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GMPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/gmpl_pkg.sv
// shared constants, types and helpers for the grid shortest path unit
// no dependencies
package gmpl_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DIST_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } cfg_reg_t;

  // cell waiting for its line store read data
  typedef struct packed {
    logic open;
    logic first_row;
    logic first_col;
    logic last;
    col_t col;
  } cell_ctx_t;

  // smallest non-zero value, zero if all are zero
  function automatic dist_t min_reached(dist_t a, dist_t b, dist_t c);
    dist_t m;
    m = a;
    if (b != '0 && (m == '0 || b < m)) m = b;
    if (c != '0 && (m == '0 || c < m)) m = c;
    return m;
  endfunction

endpackage

FILE: sv/gmpl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gmpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/grid_min_path_length_dp_unit.sv
// grid shortest path unit, top level
// depends on gmpl_pkg, gmpl_ram and grid_min_path_length_dp_unit_assert.svh
//
// cells of a grid arrive in row-major order, one open/blocked bit per input
// transaction, and every cell gives one output transaction with the length,
// counted in cells, of the shortest path from the top-left cell that moves
// down, right or diagonally down-right; 0 with reachable low where no path
// exists, and grid_end high on the bottom-right cell. num_rows (index 0) and
// num_cols (index 1) set the grid size, 0 acting as 1 and large values as the
// maximum; a write restarts the grid at the top-left cell. write them only
// while no cell is in flight. throughput is one cell per clock while results
// are taken; each cell passes the compute stage, then the output register.
// the rate is set by the line store: each cell reads its column of the row
// above in the cycle it is accepted and writes its own distance back as it
// leaves the compute stage, so the only loop is the compute stage's left-value
// update. when the previous cell writes the very column now being read
// (one-column grids), the written value is forwarded past the ram. the line
// store is never read before the row above has written it, so it needs no clearing pass after reset
module grid_min_path_length_dp_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gmpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmpl_pkg::CFG_W-1:0]  cfg_data,
  // cell input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cell_open,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gmpl_pkg::DIST_W-1:0] out_distance,
  output logic                        out_reachable,
  output logic                        out_grid_end
);

  import gmpl_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] num_rows_r, num_cols_r;
  row_t             rows_m1;
  col_t             cols_m1;

  // position of the next cell
  row_t row_r, row_nxt;
  col_t col_r, col_nxt;

  // compute stage: cell whose store read is in flight
  logic      s1_valid_r;
  cell_ctx_t s1_r;
  logic      fwd_r;       // previous write hit the column being read
  dist_t     fwd_data_r;

  // running neighbour values
  dist_t left_r, diag_r;

  // output register
  logic  out_valid_r;
  dist_t out_distance_r;
  logic  out_reachable_r;
  logic  out_grid_end_r;

  logic  in_acc, cfg_acc, s1_adv, restart;
  dist_t ram_rd_data, up_raw, up_val, left_val, diag_val, best, cell_dist;
  logic  hit_now;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc && (cfg_index inside {REG_NUM_ROWS, REG_NUM_COLS});

  // compute stage moves on whenever the output register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // clamp the size registers to 1..max, kept as last index
  always_comb begin
    if (num_rows_r == '0) begin
      rows_m1 = '0;
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(num_rows_r - 1'b1);
    end
    if (num_cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(num_cols_r - 1'b1);
    end
  end

  // raster position advance, wrapping at the end of the grid
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (col_r == cols_m1) begin
        col_nxt = '0;
        row_nxt = (row_r == rows_m1) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // line store: read on accept, write back from the compute stage
  gmpl_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_COLS)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_r.col),
    .wr_data(cell_dist),
    .rd_en  (in_acc),
    .rd_addr(col_r),
    .rd_data(ram_rd_data)
  );

  // write and read of the same column in one cycle: ram gives the old word
  assign hit_now = s1_adv && in_acc && (s1_r.col == col_r);

  // neighbour values, with edges of the grid treated as unreachable
  always_comb begin
    up_raw   = fwd_r ? fwd_data_r : ram_rd_data;
    up_val   = s1_r.first_row ? '0 : up_raw;
    left_val = s1_r.first_col ? '0 : left_r;
    diag_val = (s1_r.first_row || s1_r.first_col) ? '0 : diag_r;
    best     = min_reached(diag_val, up_val, left_val);
    if (!s1_r.open) begin
      cell_dist = '0;
    end else if (s1_r.first_row && s1_r.first_col) begin
      cell_dist = DIST_W'(1);
    end else if (best == '0) begin
      cell_dist = '0;
    end else if (best == DIST_MAX) begin
      cell_dist = DIST_MAX;          // long paths saturate
    end else begin
      cell_dist = best + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= CFG_W'(1);
      num_cols_r  <= CFG_W'(1);
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc && cfg_index == REG_NUM_ROWS) num_rows_r <= cfg_data;
      if (cfg_acc && cfg_index == REG_NUM_COLS) num_cols_r <= cfg_data;
      row_r <= row_nxt;
      col_r <= col_nxt;

      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= hit_now;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (restart) begin
        left_r <= '0;
        diag_r <= '0;
      end else if (s1_adv) begin
        left_r <= cell_dist;
        diag_r <= up_val;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.open      <= in_cell_open;
      s1_r.first_row <= (row_r == '0);
      s1_r.first_col <= (col_r == '0);
      s1_r.last      <= (row_r == rows_m1) && (col_r == cols_m1);
      s1_r.col       <= col_r;
      fwd_data_r     <= cell_dist;
    end
    if (s1_adv) begin
      out_distance_r  <= cell_dist;
      out_reachable_r <= (cell_dist != '0);
      out_grid_end_r  <= s1_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;
  assign out_grid_end  = out_grid_end_r;

`include "grid_min_path_length_dp_unit_assert.svh"

  `GMPL_ASSERT_NOW(a_col_in_range, clk, rst_n, 1'b1, (col_r <= cols_m1) && (row_r <= rows_m1), "position counter beyond grid")
  `GMPL_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_r), "compute stage lost a stalled cell")
  `GMPL_ASSERT_NEXT(a_fwd_set, clk, rst_n, hit_now, fwd_r && (fwd_data_r == up_raw), "same-column write not forwarded")
  `GMPL_ASSERT_NOW(a_reach_flag, clk, rst_n, out_valid_r, out_reachable_r == (out_distance_r != '0), "reachable flag disagrees with distance")

endmodule

FILE: test/cell_distance_checker.sv
// checker for the grid shortest path unit: tracks register writes, predicts each cell's result
// and compares the result channel against it; depends on gmpl_pkg
module cell_distance_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gmpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmpl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_cell_open,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [gmpl_pkg::DIST_W-1:0]    out_distance,
  input  logic                           out_reachable,
  input  logic                           out_grid_end,
  output int                             pending_answers,
  output int                             mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import gmpl_pkg::*;

  typedef struct packed {
    dist_t distance;
    logic  reachable;
    logic  grid_end;
  } cell_answer_t;

  cell_answer_t     answers_due[$];
  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  dist_t            line_dist [MAX_COLS];
  dist_t            left_dist;
  dist_t            diag_dist;
  row_t             row_pos;
  col_t             col_pos;
  int               mismatch_total;

  assign mismatches = mismatch_total;

  // printing stops after a couple of hundred lines, counting does not
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_total++;
    if (mismatch_total <= 200)
      $display("%0t checker: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // zero means unreachable, so it ranks above every real distance
  function automatic dist_t nearest_reached(input dist_t a, input dist_t b, input dist_t c);
    logic [DIST_W:0] ka;
    logic [DIST_W:0] kb;
    logic [DIST_W:0] kc;
    logic [DIST_W:0] k;
    ka = (a == '0) ? '1 : {1'b0, a};
    kb = (b == '0) ? '1 : {1'b0, b};
    kc = (c == '0) ? '1 : {1'b0, c};
    k = ka;
    if (kb < k) k = kb;
    if (kc < k) k = kc;
    return (k == '1) ? dist_t'(0) : k[DIST_W-1:0];
  endfunction

  function automatic void restart_walk();
    left_dist = '0;
    diag_dist = '0;
    row_pos   = '0;
    col_pos   = '0;
  endfunction

  task automatic step_cell(input logic open, output cell_answer_t ans);
    int    rows;
    int    cols;
    int    r;
    int    c;
    dist_t up;
    dist_t lf;
    dist_t dg;
    dist_t best;
    dist_t d;
    rows = clamp_dim(rows_cfg, MAX_ROWS);
    cols = clamp_dim(cols_cfg, MAX_COLS);
    r = (row_pos >= rows) ? rows - 1 : int'(row_pos);
    c = (col_pos >= cols) ? cols - 1 : int'(col_pos);
    up = (r > 0) ? line_dist[c] : dist_t'(0);
    lf = (c > 0) ? left_dist : dist_t'(0);
    dg = (r > 0 && c > 0) ? diag_dist : dist_t'(0);
    if (!open) begin
      d = '0;
    end else if (r == 0 && c == 0) begin
      d = dist_t'(1);
    end else begin
      best = nearest_reached(dg, up, lf);
      if (best == '0) d = '0;
      else if (best >= DIST_MAX) d = DIST_MAX;
      else d = best + 1'b1;
    end
    line_dist[c] = d;
    left_dist    = d;
    diag_dist    = up;
    ans.distance  = d;
    ans.reachable = (d != '0);
    ans.grid_end  = (r == rows - 1) && (c == cols - 1);
    if (c + 1 >= cols) begin
      col_pos = '0;
      row_pos = (r + 1 >= rows) ? row_t'(0) : row_t'(r + 1);
    end else begin
      col_pos = col_t'(c + 1);
      row_pos = row_t'(r);
    end
  endtask

  always @(posedge clk) begin
    cell_answer_t want;
    cell_answer_t got;
    if (!rst_n) begin
      rows_cfg = CFG_W'(1);
      cols_cfg = CFG_W'(1);
      restart_walk();
      answers_due.delete();
      pending_answers <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_ROWS: begin
            rows_cfg = cfg_data;
            restart_walk();
          end
          REG_NUM_COLS: begin
            cols_cfg = cfg_data;
            restart_walk();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{distance: out_distance, reachable: out_reachable, grid_end: out_grid_end};
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing due, distance", got.distance, 0);
        end else begin
          want = answers_due.pop_front();
          if (got.distance !== want.distance)
            report_mismatch("distance", got.distance, want.distance);
          if (got.reachable !== want.reachable)
            report_mismatch("reachable", got.reachable, want.reachable);
          if (got.grid_end !== want.grid_end)
            report_mismatch("grid_end", got.grid_end, want.grid_end);
        end
      end
      if (in_valid && in_ready) begin
        step_cell(in_cell_open, want);
        answers_due.push_back(want);
      end
      pending_answers <= answers_due.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// top of the grid shortest path testbench: clock, reset, cell and register stimulus, verdict
// depends on gmpl_pkg, grid_min_path_length_dp_unit and cell_distance_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gmpl_pkg::*;

  localparam int CLK_PERIOD = 4;

  // register indexes the block has no register behind; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // how a phase touches the size registers before its cells
  typedef enum int {PLAN_KEEP, PLAN_BOTH, PLAN_ROWS, PLAN_COLS, PLAN_SPARE} reg_plan_t;

  // receiver behaviour, switched at random
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BLOCKS} sink_mode_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_cell_open = 1'b0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [DIST_W-1:0]    out_distance;
  logic                 out_reachable;
  logic                 out_grid_end;

  int pending_answers;
  int mismatches;

  int         cells_sent = 0;
  int         burst_left = 0;
  int         hold_at;
  sink_mode_t sink_mode  = SINK_OPEN;
  int         sink_left  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  grid_min_path_length_dp_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_open  (in_cell_open),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_distance  (out_distance),
    .out_reachable (out_reachable),
    .out_grid_end  (out_grid_end)
  );

  cell_distance_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_open    (in_cell_open),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance    (out_distance),
    .out_reachable   (out_reachable),
    .out_grid_end    (out_grid_end),
    .pending_answers (pending_answers),
    .mismatches      (mismatches)
  );

  // result side back-pressure: free-flowing, coin-toss, mostly stalled, or long
  // alternating runs of stall and flow, so stalls land on every pipeline phase
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      sink_left <= $urandom_range(30, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  out_ready <= 1'b1;
      SINK_COIN:  out_ready <= 1'($urandom_range(0, 1));
      SINK_SLOW:  out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= sink_left[3];
    endcase
  end

  // one cell transaction; bursts of random length separated by random gaps,
  // with the odd long burst so the pipeline also runs flat out
  task automatic offer_cell(input logic open);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    // once per run the sender holds off until every result is back
    if (cells_sent == hold_at) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_answers != 0);
    end
    in_valid     <= 1'b1;
    in_cell_open <= open;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    cells_sent++;
  endtask

  // wait for every result, then let the two-stage pipeline settle
  task automatic settle();
    do @(posedge clk); while (pending_answers != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers are only touched with nothing in flight
  task automatic apply_plan(input reg_plan_t plan, input logic [CFG_W-1:0] rows,
                            input logic [CFG_W-1:0] cols);
    settle();
    case (plan)
      PLAN_BOTH: begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_NUM_ROWS, rows);
          write_reg(REG_NUM_COLS, cols);
        end else begin
          write_reg(REG_NUM_COLS, cols);
          write_reg(REG_NUM_ROWS, rows);
        end
      end
      PLAN_ROWS:  write_reg(REG_NUM_ROWS, rows);
      PLAN_COLS:  write_reg(REG_NUM_COLS, cols);
      PLAN_SPARE: write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                            CFG_W'($urandom));
      default: ;
    endcase
  endtask

  // fixed cell pattern, first cell in the lowest bit
  task automatic run_pattern(input reg_plan_t plan, input logic [CFG_W-1:0] rows,
                             input logic [CFG_W-1:0] cols, input logic [31:0] cells,
                             input int n);
    apply_plan(plan, rows, cols);
    for (int i = 0; i < n; i++) offer_cell(cells[i]);
    in_valid <= 1'b0;
  endtask

  // random cells, open with the given percentage
  task automatic run_phase(input reg_plan_t plan, input logic [CFG_W-1:0] rows,
                           input logic [CFG_W-1:0] cols, input int n, input int open_pct);
    apply_plan(plan, rows, cols);
    repeat (n) offer_cell($urandom_range(0, 99) < open_pct);
    in_valid <= 1'b0;
  endtask

  // small grids mostly; dense open grids carry paths deep, sparse ones break them
  task automatic run_small_grids(input int upto);
    int        rows;
    int        cols;
    int        n;
    int        pct;
    reg_plan_t plan;
    while (cells_sent < upto) begin
      rows = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
      cols = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
      n    = $urandom_range(1, 3) * ((rows > 0 ? rows : 1) * (cols > 0 ? cols : 1));
      if ($urandom_range(0, 2) == 0) n += $urandom_range(0, 20);
      case ($urandom_range(0, 3))
        0:       pct = 97;
        1:       pct = 85;
        2:       pct = 65;
        default: pct = 30;
      endcase
      case ($urandom_range(0, 9))
        0:       plan = PLAN_ROWS;
        1:       plan = PLAN_COLS;
        2:       plan = PLAN_SPARE;
        3:       plan = PLAN_KEEP;
        default: plan = PLAN_BOTH;
      endcase
      run_phase(plan, CFG_W'(rows), CFG_W'(cols), n, pct);
    end
  endtask

  initial begin
    hold_at = $urandom_range(200, 1500);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size is one by one: open start cell, then a blocked one
    run_pattern(PLAN_KEEP, '0, '0, 32'b01, 2);
    // three by four maze: an open cell with no reachable neighbour, then a wrap
    // into a fresh grid whose start is blocked
    run_pattern(PLAN_BOTH, CFG_W'(3), CFG_W'(4), 32'b1110_1101_1110_1011, 16);
    // zero sizes act as one
    run_pattern(PLAN_BOTH, '0, '0, 32'b11, 2);

    run_small_grids(500);

    // extremes: one full row at maximum width (oversized value clamps) plus a wrap,
    // a tall single column, and both registers all ones
    run_phase(PLAN_BOTH, '0, '1, 1025, 97);
    run_phase(PLAN_BOTH, CFG_W'(MAX_ROWS), CFG_W'(1), 100, 90);
    run_phase(PLAN_BOTH, '1, '1, 30, 95);
    run_phase(PLAN_BOTH, CFG_W'(MAX_ROWS), '1, 20, 80);

    run_small_grids(1870);

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_answers == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
